// File: rtl/core/rc4d_pkg.sv
// Shared types and constants for the RC4-drop keystream cipher.
// No dependencies; imported by rc4d_core, the top level and the bench.
`default_nettype none

package rc4d_pkg;

  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 9;
  localparam int DROP_W           = 16;
  localparam int FUNC_W           = 2;
  localparam int STAT_W           = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int PERM_DEPTH       = 256;
  localparam int PERM_AW          = 8;
  localparam int KEY_MIN_BYTES    = 5;
  localparam int KEY_MAX_BYTES_DEF = 256;
  localparam int RESET_KEY_LENGTH = 16;
  localparam int RESET_DROP_COUNT = 2048;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_KEY = 2'd0,
    FN_INIT     = 2'd1,
    FN_DATA     = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_LEN   = 2'd1,
    STAT_NOT_KEYED = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH = 2'd0,
    CFG_DROP_COUNT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] key_index;
    logic [BYTE_W-1:0] byte_in;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    status_t           status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/rc4d_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read during write to the same address returns the old data. No dependencies.
`default_nettype none

module rc4d_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/rc4d_core.sv
// Cipher sequencer: key store, permutation memory, key schedule, drop loop
// and keystream generation. Depends on rc4d_pkg and rc4d_ram.
`default_nettype none

module rc4d_core #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rc4d_pkg::item_t             item,
  input  wire logic                        item_fire,
  output logic                             can_accept,
  input  wire logic [rc4d_pkg::LEN_W-1:0]  key_length,
  input  wire logic [rc4d_pkg::DROP_W-1:0] drop_count,
  output logic                             res_valid,
  output rc4d_pkg::result_t                res
);

  import rc4d_pkg::*;

  localparam int KADDR_W = $clog2(KEY_MAX_BYTES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_KS_RD,
    S_KS_J,
    S_KS_WN,
    S_KS_WJ,
    S_PR_RD,
    S_PR_J,
    S_PR_WI,
    S_PR_WJ,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [BYTE_W-1:0]    i_r, i_nxt;
  logic [BYTE_W-1:0]    j_r, j_nxt;
  logic                 keyed_r, keyed_nxt;
  logic                 mode_data_r, mode_data_nxt;
  logic                 fwd_hit_r, fwd_hit_nxt;
  logic [BYTE_W-1:0]    fwd_val_r, fwd_val_nxt;
  logic [BYTE_W-1:0]    a_r, a_nxt;
  logic [BYTE_W-1:0]    b_r, b_nxt;
  logic [BYTE_W-1:0]    sum_r, sum_nxt;
  logic [BYTE_W-1:0]    n_r, n_nxt;
  logic [KADDR_W-1:0]   kpos_r, kpos_nxt;
  logic [DROP_W-1:0]    drop_r, drop_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic [BYTE_W-1:0]    resp_byte_r, resp_byte_nxt;
  status_t              resp_stat_r, resp_stat_nxt;

  // memory ports
  logic                 p_we;
  logic [PERM_AW-1:0]   p_waddr, p_raddr;
  logic [BYTE_W-1:0]    p_wdata, p_rdata;
  logic                 k_we;
  logic [KADDR_W-1:0]   k_waddr, k_raddr;
  logic [BYTE_W-1:0]    k_wdata, k_rdata;

  logic [BYTE_W-1:0]    a_cur;
  logic [BYTE_W-1:0]    ks_byte;
  logic [BYTE_W-1:0]    i_inc;
  logic [BYTE_W-1:0]    j_ksa;
  logic                 len_ok;
  logic                 kidx_ok;
  logic                 kpos_last;

  rc4d_ram #(
    .DEPTH (PERM_DEPTH),
    .AW    (PERM_AW),
    .DW    (BYTE_W)
  ) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4d_ram #(
    .DEPTH (KEY_MAX_BYTES),
    .AW    (KADDR_W),
    .DW    (BYTE_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  // S[i] read may overlap the S[j] write of the previous step: forward it
  assign a_cur     = fwd_hit_r ? fwd_val_r : p_rdata;
  // S[a+b] was read before the swap landed; patch the two swapped entries
  assign ks_byte   = (sum_r == j_r) ? a_r : ((sum_r == i_r) ? b_r : p_rdata);
  assign i_inc     = i_r + 8'd1;
  assign j_ksa     = j_r + p_rdata + k_rdata;
  assign len_ok    = (key_length >= LEN_W'(KEY_MIN_BYTES)) &&
                     (key_length <= LEN_W'(KEY_MAX_BYTES));
  assign kidx_ok   = ({1'b0, item.key_index} < LEN_W'(KEY_MAX_BYTES));
  assign kpos_last = ((LEN_W'(kpos_r) + LEN_W'(1)) == key_length);

  assign can_accept = (state_r == S_IDLE) || ((state_r == S_PR_WJ) && mode_data_r);

  // next-state and datapath control
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    keyed_nxt     = keyed_r;
    mode_data_nxt = mode_data_r;
    fwd_hit_nxt   = fwd_hit_r;
    fwd_val_nxt   = fwd_val_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    kpos_nxt      = kpos_r;
    drop_nxt      = drop_r;
    byte_nxt      = byte_r;
    resp_byte_nxt = resp_byte_r;
    resp_stat_nxt = resp_stat_r;

    p_we    = 1'b0;
    p_waddr = j_r;
    p_wdata = a_r;
    p_raddr = i_inc;
    k_we    = 1'b0;
    k_waddr = item.key_index[KADDR_W-1:0];
    k_wdata = item.byte_in;
    k_raddr = kpos_r;

    res_valid    = 1'b0;
    res.byte_out = resp_byte_r;
    res.status   = resp_stat_r;

    unique case (state_r)
      S_IDLE: begin
      end

      // identity permutation, one entry a cycle
      S_FILL: begin
        p_we    = 1'b1;
        p_waddr = n_r;
        p_wdata = n_r;
        n_nxt   = n_r + 8'd1;
        if (n_r == 8'hFF) begin
          state_nxt = S_KS_RD;
          kpos_nxt  = '0;
          j_nxt     = '0;
        end
      end

      // key schedule: read S[n] and K[n mod len]
      S_KS_RD: begin
        p_raddr   = n_r;
        state_nxt = S_KS_J;
      end

      S_KS_J: begin
        a_nxt     = p_rdata;
        j_nxt     = j_ksa;
        p_raddr   = j_ksa;
        state_nxt = S_KS_WN;
      end

      S_KS_WN: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = p_rdata;
        state_nxt = S_KS_WJ;
      end

      S_KS_WJ: begin
        p_we     = 1'b1;
        p_waddr  = j_r;
        p_wdata  = a_r;
        n_nxt    = n_r + 8'd1;
        kpos_nxt = kpos_last ? '0 : kpos_r + 1'b1;
        if (n_r == 8'hFF) begin
          i_nxt         = '0;
          j_nxt         = '0;
          drop_nxt      = drop_count;
          mode_data_nxt = 1'b0;
          if (drop_count == '0) begin
            keyed_nxt     = 1'b1;
            resp_byte_nxt = '0;
            resp_stat_nxt = STAT_OK;
            state_nxt     = S_RESP;
          end else begin
            state_nxt = S_PR_RD;
          end
        end else begin
          state_nxt = S_KS_RD;
        end
      end

      // first read of the drop loop
      S_PR_RD: begin
        p_raddr     = i_inc;
        i_nxt       = i_inc;
        fwd_hit_nxt = 1'b0;
        state_nxt   = S_PR_J;
      end

      S_PR_J: begin
        a_nxt     = a_cur;
        j_nxt     = j_r + a_cur;
        p_raddr   = j_r + a_cur;
        state_nxt = S_PR_WI;
      end

      S_PR_WI: begin
        b_nxt     = p_rdata;
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = p_rdata;
        p_raddr   = a_r + p_rdata;
        sum_nxt   = a_r + p_rdata;
        state_nxt = S_PR_WJ;
      end

      // finish the swap; emit a data result, end the drop loop or run the next drop step
      S_PR_WJ: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = a_r;
        if (mode_data_r) begin
          res_valid    = 1'b1;
          res.byte_out = byte_r ^ ks_byte;
          res.status   = STAT_OK;
          state_nxt    = S_IDLE;
        end else if (drop_r == DROP_W'(1)) begin
          drop_nxt      = '0;
          keyed_nxt     = 1'b1;
          resp_byte_nxt = '0;
          resp_stat_nxt = STAT_OK;
          state_nxt     = S_RESP;
        end else begin
          drop_nxt    = drop_r - 1'b1;
          p_raddr     = i_inc;
          i_nxt       = i_inc;
          fwd_hit_nxt = (i_inc == j_r);
          fwd_val_nxt = a_r;
          state_nxt   = S_PR_J;
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // new transaction; overrides the return to idle
    if (item_fire) begin
      unique case (item.func)
        FN_LOAD_KEY: begin
          k_we = kidx_ok;
        end
        FN_INIT: begin
          if (len_ok) begin
            n_nxt     = '0;
            state_nxt = S_FILL;
          end else begin
            resp_byte_nxt = '0;
            resp_stat_nxt = STAT_BAD_LEN;
            state_nxt     = S_RESP;
          end
        end
        FN_DATA: begin
          if (keyed_r) begin
            p_raddr       = i_inc;
            i_nxt         = i_inc;
            fwd_hit_nxt   = (state_r == S_PR_WJ) && (i_inc == j_r);
            fwd_val_nxt   = a_r;
            byte_nxt      = item.byte_in;
            mode_data_nxt = 1'b1;
            state_nxt     = S_PR_J;
          end else begin
            resp_byte_nxt = item.byte_in;
            resp_stat_nxt = STAT_NOT_KEYED;
            state_nxt     = S_RESP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state and registered datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      mode_data_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      keyed_r     <= keyed_nxt;
      mode_data_r <= mode_data_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
    end
    fwd_val_r   <= fwd_val_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    sum_r       <= sum_nxt;
    n_r         <= n_nxt;
    kpos_r      <= kpos_nxt;
    drop_r      <= drop_nxt;
    byte_r      <= byte_nxt;
    resp_byte_r <= resp_byte_nxt;
    resp_stat_r <= resp_stat_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/rc4_drop_keystream_cipher.sv
// Key load: no result. Data byte (keyed): XORed with the next keystream byte; a new data
// byte is taken only once the last one reaches its final swap write, set by the read/swap/read
// sequence on the single permutation memory. Not-keyed data or bad-length init: a result
// with an error status. Good init: identity fill, key schedule, then drop_count dropped
// keystream bytes. Reset (synchronous, active low) clears control, indexes,
// keyed flag and config (key_length 16, drop_count 2048); memories not cleared.
// Top level: config registers, 2-entry result queue; depends on rc4d_pkg, rc4d_core.
`default_nettype none

module rc4_drop_keystream_cipher #(
  parameter int KEY_MAX_BYTES = rc4d_pkg::KEY_MAX_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [15:0]                    in_tdata,   // [7:0] key_index, [15:8] byte_in
  input  wire logic [rc4d_pkg::FUNC_W-1:0]    in_tuser,   // [1:0] func
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] byte_out
  output logic [rc4d_pkg::STAT_W-1:0]         out_tuser,  // [1:0] status
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rc4d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rc4d_pkg::DROP_W-1:0]    cfg_data
);

  import rc4d_pkg::*;

  logic [LEN_W-1:0]  key_length_r;
  logic [DROP_W-1:0] drop_count_r;
  item_t             item;
  logic              item_fire;
  logic              can_accept;
  logic              res_valid;
  result_t           res;
  logic [1:0]        cnt_r;
  result_t           e0_r, e1_r;
  logic              pop;
  logic [2:0]        occ_nxt;
  logic              room;

  assign item.func      = in_tuser;
  assign item.key_index = in_tdata[7:0];
  assign item.byte_in   = in_tdata[15:8];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= LEN_W'(RESET_KEY_LENGTH);
      drop_count_r <= DROP_W'(RESET_DROP_COUNT);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH: key_length_r <= cfg_data[LEN_W-1:0];
        CFG_DROP_COUNT: drop_count_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // accept only when the queue keeps a slot for this transaction's result
  assign pop       = out_tvalid && out_tready;
  assign occ_nxt   = {1'b0, cnt_r} + {2'b00, res_valid} - {2'b00, pop};
  assign room      = (occ_nxt < 3'd2);
  assign in_tready = can_accept && room;
  assign item_fire = in_tvalid && in_tready;

  rc4d_core #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_fire  (item_fire),
    .can_accept (can_accept),
    .key_length (key_length_r),
    .drop_count (drop_count_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // two-entry result queue, head in e0_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= occ_nxt[1:0];
    end
    priority if (pop && res_valid) begin
      if (cnt_r == 2'd2) begin
        e0_r <= e1_r;
        e1_r <= res;
      end else begin
        e0_r <= res;
      end
    end else if (pop) begin
      e0_r <= e1_r;
    end else if (res_valid) begin
      if (cnt_r == 2'd0) begin
        e0_r <= res;
      end else begin
        e1_r <= res;
      end
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = e0_r.byte_out;
  assign out_tuser  = e0_r.status;

endmodule

`default_nettype wire

// File: bench/rc4_drop_keystream_cipher_test.sv
// Self-checking bench for rc4_drop_keystream_cipher: an RC4-drop model predicts every
// result, and directed and random item streams run under varied stall patterns.
// Depends on rc4d_pkg and the cipher RTL.
`timescale 1ns / 100ps

module rc4_drop_keystream_cipher_test;
  import rc4d_pkg::*;

  localparam logic [FUNC_W-1:0]    FN_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;   // [7:0] key_index, [15:8] byte_in
  logic [FUNC_W-1:0]    in_tuser = '0;   // [1:0] func
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // [7:0] byte_out
  logic [STAT_W-1:0]    out_tuser;       // [1:0] status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DROP_W-1:0]    cfg_data = '0;

  // cipher model state
  logic [7:0]        sbox [256];
  logic [7:0]        key_mem [256];
  logic [7:0]        ks_i = '0;
  logic [7:0]        ks_j = '0;
  bit                is_keyed = 1'b0;
  logic [LEN_W-1:0]  key_len_reg = LEN_W'(RESET_KEY_LENGTH);
  logic [DROP_W-1:0] drop_reg = DROP_W'(RESET_DROP_COUNT);
  result_t           cipher_results_due [$];

  // stimulus bookkeeping
  bit key_loaded [256];
  int items_sent = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  rc4_drop_keystream_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one PRGA step: swap S[i], S[j] and return S[S[i] + S[j]]
  function automatic logic [7:0] ks_next();
    logic [7:0] a, b, sum;
    ks_i = ks_i + 8'd1;
    a = sbox[ks_i];
    ks_j = ks_j + a;
    b = sbox[ks_j];
    sbox[ks_i] = b;
    sbox[ks_j] = a;
    sum = a + b;
    return sbox[sum];
  endfunction

  // KSA over the loaded key, then throw away drop_reg keystream bytes
  function automatic status_t schedule_key();
    logic [7:0] j, t;
    int n;
    if (key_len_reg < KEY_MIN_BYTES || key_len_reg > KEY_MAX_BYTES_DEF)
      return STAT_BAD_LEN;
    for (n = 0; n < 256; n++)
      sbox[n] = 8'(n);
    j = '0;
    for (n = 0; n < 256; n++) begin
      t = sbox[n];
      j = j + t + key_mem[n % key_len_reg];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    ks_i = '0;
    ks_j = '0;
    for (n = 0; n < drop_reg; n++)
      void'(ks_next());
    is_keyed = 1'b1;
    return STAT_OK;
  endfunction

  // expected result (if any) of one accepted input transaction
  function automatic void predict_cipher_item(input logic [FUNC_W-1:0] fn,
                                              input logic [7:0] kidx,
                                              input logic [7:0] val);
    result_t res;
    res.byte_out = '0;
    res.status   = STAT_OK;
    case (fn)
      FN_LOAD_KEY: key_mem[kidx] = val;
      FN_INIT: begin
        res.status = schedule_key();
        cipher_results_due.push_back(res);
      end
      FN_DATA: begin
        if (!is_keyed) begin
          res.byte_out = val;
          res.status   = STAT_NOT_KEYED;
        end else begin
          res.byte_out = val ^ ks_next();
        end
        cipher_results_due.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // check results, then track register writes and input transactions
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (cipher_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result byte_out %02h status %0d",
                     $time, out_tdata, out_tuser);
        end else begin
          want = cipher_results_due.pop_front();
          if (out_tdata !== want.byte_out || out_tuser !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: byte_out exp %02h got %02h, status exp %0d got %0d",
                       $time, want.byte_out, out_tdata, want.status, out_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_LENGTH: key_len_reg = cfg_data[LEN_W-1:0];
          CFG_DROP_COUNT: drop_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_cipher_item(in_tuser, in_tdata[7:0], in_tdata[15:8]);
    end
  end

  // result sink: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one item and return at the edge that accepts it; valid stays up
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [7:0] kidx,
                           input logic [7:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tuser  <= FUNC_W'($urandom);
      in_tdata  <= 16'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {val, kidx};
    do @(posedge clk); while (!in_tready);
    if (fn != FN_UNUSED)
      items_sent++;
  endtask

  // stop offering, wait for every pending result, then let a key load settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cipher_results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DROP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // both registers, with junk above the key length field and sometimes a spare index
  task automatic configure(input logic [LEN_W-1:0] len, input logic [DROP_W-1:0] drop);
    logic [DROP_W-1:0] word;
    word = DROP_W'($urandom);
    word[LEN_W-1:0] = len;
    if ($urandom_range(1))
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), DROP_W'($urandom));
    write_reg(CFG_KEY_LENGTH, word);
    write_reg(CFG_DROP_COUNT, drop);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_item(FN_LOAD_KEY, 8'(k), 8'($urandom));
      key_loaded[k] = 1'b1;
    end
  endtask

  function automatic bit key_covered(input int len);
    int k;
    for (k = 0; k < len; k++)
      if (!key_loaded[k])
        return 1'b0;
    return 1'b1;
  endfunction

  // data ahead of any init passes through; first init uses the reset register values
  task automatic test_before_key();
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    send_item(FN_DATA, 8'h00, 8'h00);
    send_item(FN_DATA, 8'hFF, 8'hFF);
    send_item(FN_UNUSED, 8'h5A, 8'hA5);
    load_key(RESET_KEY_LENGTH);
    send_item(FN_LOAD_KEY, 8'h00, 8'h00);
    send_item(FN_LOAD_KEY, 8'hFF, 8'hFF);
    key_loaded[255] = 1'b1;
    send_item(FN_INIT, 8'h00, 8'h00);
    send_item(FN_DATA, 8'h00, 8'h00);
    send_item(FN_DATA, 8'hFF, 8'hFF);
  endtask

  // lengths outside the legal range and at its lower edge; bad ones keep the stream
  task automatic test_key_length_limits();
    int bad_len [4];
    int b;
    bad_len = '{0, KEY_MIN_BYTES - 1, KEY_MAX_BYTES_DEF + 1, 511};
    for (b = 0; b < 4; b++) begin
      wait_idle();
      configure(LEN_W'(bad_len[b]), 16'd3);
      send_item(FN_INIT, 8'($urandom), 8'($urandom));
      send_item(FN_DATA, 8'($urandom), 8'($urandom));
    end
    wait_idle();
    configure(LEN_W'(KEY_MIN_BYTES), 16'd1);
    send_item(FN_INIT, 8'($urandom), 8'($urandom));
    send_item(FN_DATA, 8'($urandom), 8'h00);
    send_item(FN_DATA, 8'($urandom), 8'hFF);
  endtask

  task automatic test_drop_extremes();
    wait_idle();
    configure(LEN_W'(KEY_MIN_BYTES), 16'h0000);
    send_item(FN_INIT, 8'($urandom), 8'($urandom));
    repeat (3) send_item(FN_DATA, 8'($urandom), 8'($urandom));
    wait_idle();
    configure(LEN_W'(KEY_MIN_BYTES), 16'hFFFF);
    send_item(FN_INIT, 8'($urandom), 8'($urandom));
    repeat (2) send_item(FN_DATA, 8'($urandom), 8'($urandom));
  endtask

  // sink holds off while data keeps coming, so the result queue fills and input stalls
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    repeat (40) send_item(FN_DATA, 8'($urandom), 8'($urandom));
    wait_idle();
  endtask

  // mostly full key load, init, data burst; some partial keys, bad lengths and noise
  task automatic test_random(input int count);
    int stop_at, seq, pick, len, k;
    logic [DROP_W-1:0] drop;
    bit good;
    stop_at = items_sent + count;
    seq = 0;
    while (items_sent < stop_at) begin
      wait_idle();
      case (seq % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      pick = $urandom_range(99);
      if (seq == 0 || pick < 6)
        len = KEY_MAX_BYTES_DEF;
      else if (pick < 16)
        len = $urandom_range(1) ? $urandom_range(KEY_MIN_BYTES - 1, 0)
                                : $urandom_range(511, KEY_MAX_BYTES_DEF + 1);
      else
        len = $urandom_range(32, KEY_MIN_BYTES);
      pick = $urandom_range(99);
      if (pick < 4)
        drop = DROP_W'($urandom_range(4096, 1025));
      else if (pick < 20)
        drop = DROP_W'($urandom_range(1024, 65));
      else
        drop = DROP_W'($urandom_range(64, 0));
      configure(LEN_W'(len), drop);
      good = (len >= KEY_MIN_BYTES && len <= KEY_MAX_BYTES_DEF);
      if (good && $urandom_range(9) != 0) begin
        load_key(len);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          k = $urandom_range(255, 0);
          send_item(FN_LOAD_KEY, 8'(k), 8'($urandom));
          key_loaded[k] = 1'b1;
        end
      end
      if (!good || key_covered(len))
        send_item(FN_INIT, 8'($urandom), 8'($urandom));
      repeat ($urandom_range(40, 8)) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          k = $urandom_range(255, 0);
          send_item(FN_LOAD_KEY, 8'(k), 8'($urandom));
          key_loaded[k] = 1'b1;
        end else if (pick < 7) begin
          send_item(FN_UNUSED, 8'($urandom), 8'($urandom));
        end else if (pick < 9 && (!good || key_covered(len))) begin
          send_item(FN_INIT, 8'($urandom), 8'($urandom));
        end else begin
          send_item(FN_DATA, 8'($urandom), 8'($urandom));
        end
      end
      seq++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_before_key();
    test_key_length_limits();
    test_drop_extremes();
    test_backpressure();
    test_random(640);
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && cipher_results_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: rc4_drop_keystream_cipher.f
rtl/core/rc4d_pkg.sv
rtl/core/rc4d_ram.sv
rtl/core/rc4d_core.sv
rtl/core/rc4_drop_keystream_cipher.sv
bench/rc4_drop_keystream_cipher_test.sv
